@@ rtl/core/sip_pkg.sv @@
`timescale 1ns / 1ps
package sip_pkg;

  localparam int LON_W   = 29;            // longitude field width
  localparam int LAT_W   = 28;            // latitude field width
  localparam int NDIF_W  = LON_W + 1;     // longitude difference
  localparam int ADIF_W  = LAT_W + 1;     // latitude difference
  localparam int PROD_W  = NDIF_W + ADIF_W;
  localparam int CROSS_W = PROD_W + 1;    // D, Qx, Qy
  localparam int MAG_W   = CROSS_W;       // magnitudes of the cross terms
  localparam int STEP_N  = NDIF_W;        // quotient bits of the offset division

  localparam int SIP_QUEUE_DEPTH = 4;

  // One classified segment pair, handed from the front part to the back part.
  typedef struct packed {
    logic                    hit;
    logic signed [LON_W-1:0] base_lon;
    logic signed [LAT_W-1:0] base_lat;
    logic                    lon_neg;
    logic                    lat_neg;
    logic [STEP_N-1:0]       lon_mag;
    logic [STEP_N-1:0]       lat_mag;
    logic [MAG_W-1:0]        qx;
    logic [MAG_W-1:0]        d;
  } sip_job_t;

  // Partial remainder and quotient of one multiply-divide lane.
  typedef struct packed {
    logic [MAG_W-1:0]  r;
    logic [STEP_N-1:0] q;
  } sip_lane_t;

  typedef struct packed {
    sip_job_t  job;
    sip_lane_t lon;
    sip_lane_t lat;
  } sip_stage_t;

endpackage

@@ rtl/core/sip_if.sv @@
`timescale 1ns / 1ps
interface sip_pair_if;
  logic                            valid;
  logic                            ready;
  logic signed [sip_pkg::LON_W-1:0] first_start_lon;
  logic signed [sip_pkg::LAT_W-1:0] first_start_lat;
  logic signed [sip_pkg::LON_W-1:0] first_end_lon;
  logic signed [sip_pkg::LAT_W-1:0] first_end_lat;
  logic signed [sip_pkg::LON_W-1:0] second_start_lon;
  logic signed [sip_pkg::LAT_W-1:0] second_start_lat;
  logic signed [sip_pkg::LON_W-1:0] second_end_lon;
  logic signed [sip_pkg::LAT_W-1:0] second_end_lat;

  modport source (output valid, first_start_lon, first_start_lat, first_end_lon,
                  first_end_lat, second_start_lon, second_start_lat, second_end_lon,
                  second_end_lat, input ready);
  modport sink (input valid, first_start_lon, first_start_lat, first_end_lon,
                first_end_lat, second_start_lon, second_start_lat, second_end_lon,
                second_end_lat, output ready);
endinterface

interface sip_point_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic signed [sip_pkg::LON_W-1:0] hit_lon;
  logic signed [sip_pkg::LAT_W-1:0] hit_lat;

  modport source (output valid, hit, hit_lon, hit_lat, input ready);
  modport sink (input valid, hit, hit_lon, hit_lat, output ready);
endinterface

@@ rtl/core/segment_intersection_point.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Transaction contents
// pairs    in         two segments: four endpoints, lon/lat in microdegrees
// points   out        hit flag and the rounded meeting point
//
// One transaction is taken every cycle unless the front stalls. A pair passes
// the four front stages, the queue, and the back pipeline, where one bit of
// |n| is taken per stage to form the quotient |n|*|Qx|/|D|.
// Reset (rst, synchronous) clears all valid bits and the queue pointers.
// The front stalls only when the queue is full; the back stalls only when
// a result waits on points.
module segment_intersection_point import sip_pkg::*; #(
  parameter int QueueDepth = SIP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  sip_pair_if.sink    pairs,
  sip_point_if.source points
);

  // Front: differences, cross products, and classification of each pair
  // into parallel, crossing or missing. Its output is a job that already
  // carries the base point, so the back part only adds a scaled offset.
  logic     job_valid;
  sip_job_t front_job;
  logic     queue_full;

  sip_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pairs      (pairs),
    .queue_full (queue_full),
    .job_valid  (job_valid),
    .job        (front_job)
  );

  // The queue decouples the two halves so that a stalled output does not
  // stop the front stages until the queue has filled.
  logic     queue_empty;
  logic     job_pop;
  sip_job_t back_job;

  sip_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_data (front_job),
    .full      (queue_full),
    .pop       (job_pop),
    .empty     (queue_empty),
    .pop_data  (back_job)
  );

  // Back: pipelined multiply-divide for both coordinates, rounding, and
  // the final add onto the base point, which lands in the output register.
  sip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_ready (!queue_empty),
    .job       (back_job),
    .job_pop   (job_pop),
    .points    (points)
  );

endmodule

@@ rtl/core/sip_front.sv @@
`timescale 1ns / 1ps
module sip_front import sip_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  sip_pair_if.sink pairs,
  input  logic     queue_full,
  output logic     job_valid,
  output sip_job_t job
);

  typedef struct packed {
    logic signed [LON_W-1:0] a_lon;
    logic signed [LAT_W-1:0] a_lat;
    logic signed [LON_W-1:0] b_lon;
    logic signed [LAT_W-1:0] b_lat;
    logic                    a_on;
    logic                    b_on;
  } carry_t;

  typedef struct packed {
    logic              lon_neg;
    logic              lat_neg;
    logic [STEP_N-1:0] lon_mag;
    logic [STEP_N-1:0] lat_mag;
  } dir_t;

  logic adv;
  logic v1, v2, v3, v4;
  carry_t c1, c2, c3, c4;
  dir_t   n2, n3, n4;

  logic signed [NDIF_W-1:0] nx, mx, px;
  logic signed [ADIF_W-1:0] ny, my, py;
  logic signed [PROD_W-1:0] p_d1, p_d2, p_x1, p_x2, p_y1, p_y2;
  logic signed [CROSS_W-1:0] d3, qx3, qy3;
  logic [MAG_W-1:0] ad, aqx, aqy;
  logic d_zero, d_neg, qx_neg, qy_neg, qx_zero, qy_zero;
  logic same, div_hit;

  assign adv         = !(v4 && queue_full);
  assign pairs.ready = adv;
  assign job_valid   = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= pairs.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: direction vectors, start offset and endpoint coincidence.
  always_ff @(posedge clk) begin
    if (adv) begin
      nx <= NDIF_W'(pairs.first_end_lon) - NDIF_W'(pairs.first_start_lon);
      ny <= ADIF_W'(pairs.first_end_lat) - ADIF_W'(pairs.first_start_lat);
      mx <= NDIF_W'(pairs.second_start_lon) - NDIF_W'(pairs.second_end_lon);
      my <= ADIF_W'(pairs.second_start_lat) - ADIF_W'(pairs.second_end_lat);
      px <= NDIF_W'(pairs.second_start_lon) - NDIF_W'(pairs.first_start_lon);
      py <= ADIF_W'(pairs.second_start_lat) - ADIF_W'(pairs.first_start_lat);
      c1.a_lon <= pairs.first_start_lon;
      c1.a_lat <= pairs.first_start_lat;
      c1.b_lon <= pairs.first_end_lon;
      c1.b_lat <= pairs.first_end_lat;
      c1.a_on  <= (pairs.first_start_lon == pairs.second_start_lon &&
                   pairs.first_start_lat == pairs.second_start_lat) ||
                  (pairs.first_start_lon == pairs.second_end_lon &&
                   pairs.first_start_lat == pairs.second_end_lat);
      c1.b_on  <= (pairs.first_end_lon == pairs.second_start_lon &&
                   pairs.first_end_lat == pairs.second_start_lat) ||
                  (pairs.first_end_lon == pairs.second_end_lon &&
                   pairs.first_end_lat == pairs.second_end_lat);
    end
  end

  // Stage 2: the six cross products, one multiplier each.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_d1 <= PROD_W'(nx) * PROD_W'(my);
      p_d2 <= PROD_W'(ny) * PROD_W'(mx);
      p_x1 <= PROD_W'(my) * PROD_W'(px);
      p_x2 <= PROD_W'(mx) * PROD_W'(py);
      p_y1 <= PROD_W'(nx) * PROD_W'(py);
      p_y2 <= PROD_W'(ny) * PROD_W'(px);
      c2 <= c1;
      n2.lon_neg <= nx[NDIF_W-1];
      n2.lat_neg <= ny[ADIF_W-1];
      n2.lon_mag <= nx[NDIF_W-1] ? STEP_N'(-nx) : STEP_N'(nx);
      n2.lat_mag <= ny[ADIF_W-1] ? STEP_N'(unsigned'(-ny)) : STEP_N'(unsigned'(ny));
    end
  end

  // Stage 3: D, Qx and Qy.
  always_ff @(posedge clk) begin
    if (adv) begin
      d3  <= CROSS_W'(p_d1) - CROSS_W'(p_d2);
      qx3 <= CROSS_W'(p_x1) - CROSS_W'(p_x2);
      qy3 <= CROSS_W'(p_y1) - CROSS_W'(p_y2);
      c3  <= c2;
      n3  <= n2;
    end
  end

  // Stage 4: magnitudes, sign flags and zero flags.
  always_ff @(posedge clk) begin
    if (adv) begin
      ad      <= d3[CROSS_W-1] ? MAG_W'(-d3) : MAG_W'(d3);
      aqx     <= qx3[CROSS_W-1] ? MAG_W'(-qx3) : MAG_W'(qx3);
      aqy     <= qy3[CROSS_W-1] ? MAG_W'(-qy3) : MAG_W'(qy3);
      d_zero  <= (d3 == '0);
      d_neg   <= d3[CROSS_W-1];
      qx_neg  <= qx3[CROSS_W-1];
      qy_neg  <= qy3[CROSS_W-1];
      qx_zero <= (qx3 == '0);
      qy_zero <= (qy3 == '0);
      c4 <= c3;
      n4 <= n3;
    end
  end

  // Classification into a job for the back part. Jobs with no division get
  // a zero offset and a unit divisor, so the back part treats all alike.
  assign same = (!d_neg && !qx_neg && !qy_neg) ||
                (d_neg && (qx_neg || qx_zero) && (qy_neg || qy_zero));
  assign div_hit = !d_zero && same && (aqx <= ad) && (aqy <= ad);

  always_comb begin
    job          = '0;
    job.d        = MAG_W'(1);
    if (d_zero) begin
      job.hit = c4.a_on || c4.b_on;
      if (c4.a_on) begin
        job.base_lon = c4.a_lon;
        job.base_lat = c4.a_lat;
      end else if (c4.b_on) begin
        job.base_lon = c4.b_lon;
        job.base_lat = c4.b_lat;
      end
    end else if (div_hit) begin
      job.hit      = 1'b1;
      job.base_lon = c4.a_lon;
      job.base_lat = c4.a_lat;
      job.lon_neg  = n4.lon_neg;
      job.lat_neg  = n4.lat_neg;
      job.lon_mag  = n4.lon_mag;
      job.lat_mag  = n4.lat_mag;
      job.qx       = aqx;
      job.d        = ad;
    end
  end

endmodule

@@ rtl/core/sip_queue.sv @@
`timescale 1ns / 1ps
module sip_queue import sip_pkg::*; #(
  parameter int Depth = SIP_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  sip_job_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output sip_job_t pop_data
);

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  sip_job_t slots [Depth];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full     = (count == CNT_W'(Depth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/sip_back.sv @@
`timescale 1ns / 1ps
module sip_back import sip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_ready,
  input  sip_job_t    job,
  output logic        job_pop,
  sip_point_if.source points
);

  // One bit of |n| per stage: r = 2r + bit*Qx, then take off D or 2D.
  function automatic sip_lane_t lane_step(sip_lane_t l, logic b,
                                          logic [MAG_W-1:0] qx,
                                          logic [MAG_W-1:0] d);
    logic [MAG_W+1:0] r2, s1, s2;
    logic ge1, ge2;
    sip_lane_t o;
    r2  = {1'b0, l.r, 1'b0} + (b ? {2'b00, qx} : '0);
    s1  = r2 - {2'b00, d};
    s2  = r2 - {1'b0, d, 1'b0};
    ge1 = (r2 >= {2'b00, d});
    ge2 = (r2 >= {1'b0, d, 1'b0});
    o.q = {l.q[STEP_N-2:0], 1'b0} + (ge2 ? STEP_N'(2) : ge1 ? STEP_N'(1) : '0);
    o.r = ge2 ? MAG_W'(s2) : ge1 ? MAG_W'(s1) : MAG_W'(r2);
    return o;
  endfunction

  logic adv;
  logic vld [STEP_N+1];
  sip_stage_t st [STEP_N+1];
  logic rnd_vld, out_vld;
  sip_job_t rnd_job;
  logic [STEP_N:0] off_lon, off_lat;
  logic out_hit;
  logic signed [LON_W-1:0] out_lon;
  logic signed [LAT_W-1:0] out_lat;

  assign adv     = !out_vld || points.ready;
  assign job_pop = adv && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= STEP_N; i++) begin
        vld[i] <= 1'b0;
      end
      rnd_vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld[0] <= job_ready;
      for (int i = 0; i < STEP_N; i++) begin
        vld[i+1] <= vld[i];
      end
      rnd_vld <= vld[STEP_N];
      out_vld <= rnd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].job <= job;
      st[0].lon <= '0;
      st[0].lat <= '0;
    end
  end

  for (genvar g = 0; g < STEP_N; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        st[g+1].job <= st[g].job;
        st[g+1].lon <= lane_step(st[g].lon, st[g].job.lon_mag[STEP_N-1-g],
                                 st[g].job.qx, st[g].job.d);
        st[g+1].lat <= lane_step(st[g].lat, st[g].job.lat_mag[STEP_N-1-g],
                                 st[g].job.qx, st[g].job.d);
      end
    end
  end

  // Round to nearest, ties away from zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      rnd_job <= st[STEP_N].job;
      off_lon <= (STEP_N+1)'(st[STEP_N].lon.q) +
                 (STEP_N+1)'({st[STEP_N].lon.r, 1'b0} >= {1'b0, st[STEP_N].job.d});
      off_lat <= (STEP_N+1)'(st[STEP_N].lat.q) +
                 (STEP_N+1)'({st[STEP_N].lat.r, 1'b0} >= {1'b0, st[STEP_N].job.d});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit <= rnd_job.hit;
      out_lon <= rnd_job.lon_neg ? rnd_job.base_lon - LON_W'(off_lon)
                                 : rnd_job.base_lon + LON_W'(off_lon);
      out_lat <= rnd_job.lat_neg ? rnd_job.base_lat - LAT_W'(off_lat)
                                 : rnd_job.base_lat + LAT_W'(off_lat);
    end
  end

  assign points.valid   = out_vld;
  assign points.hit     = out_hit;
  assign points.hit_lon = out_lon;
  assign points.hit_lat = out_lat;

endmodule
